[rtl/cluster_allocation_table_defines.svh]
`ifndef CLUSTER_ALLOCATION_TABLE_DEFINES_SVH
`define CLUSTER_ALLOCATION_TABLE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define CAT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CAT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/cat_pkg.sv]
package cat_pkg;

    localparam int CLUSTERS   = 4096;
    localparam int IDX_W      = $clog2(CLUSTERS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ENTRY_W    = 28;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int FIRST_DATA = 2;
    localparam int MAX_FREE   = CLUSTERS - 3;

    // stream payload widths, rounded up to whole bytes
    localparam int IN_BITS     = IDX_W + ENTRY_W + IDX_W;
    localparam int OUT_BITS    = IDX_W + ENTRY_W + CNT_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // only the low 28 bits of an entry are stored; the top four reserved bits
    // are not kept in the table
    localparam logic [ENTRY_W-1:0] END_CHAIN   = 28'hFFF_FFFF;
    localparam logic [ENTRY_W-1:0] MEDIA_ENTRY = 28'hFFF_FFF8;
    localparam logic [ENTRY_W-1:0] BAD_MARK    = 28'hFFF_FFF7;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd3;

    localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STS_NO_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] STS_RANGE   = 2'd2;
    localparam logic [STATUS_W-1:0] STS_ABORT   = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [IDX_W-1:0]   entry_index;
        logic [ENTRY_W-1:0] entry_value;
        logic [IDX_W-1:0]   link_from;
    } cat_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    cluster;
        logic [ENTRY_W-1:0]  entry_value_out;
        logic [CNT_W-1:0]    free_clusters;
    } cat_result_t;

endpackage

[rtl/cluster_allocation_table.sv]
// flow to m_axis_tvalid, via the output register: a write goes straight to the result,
// a read waits for the table data, an allocate scans from the hint for a free entry and
// a free clears each link of the chain; a scan that reaches the limit wraps to cluster 2
// throughput: one transaction at a time through the table (one read, one write port); the next
// is taken once the result sits in the output register
// reset (aresetn low, synchronous): hint 3, free count 4093, clusters_in_use 4096, then a
// clearing pass over the whole table during which s_axis_tready stays low
module cluster_allocation_table
    import cat_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    // configuration: clusters_in_use
    input  logic                   cfg_wr_en,
    input  logic [CNT_W-1:0]       cfg_wr_data,

    // command transactions
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // entry_index, entry_value, link_from
    input  logic [CMD_W-1:0]       s_axis_tuser,   // cmd

    // result transactions
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // cluster, entry_value_out, free_clusters
    output logic [STATUS_W-1:0]    m_axis_tuser    // status
);

    cat_cmd_t    cmd;
    cat_result_t res;
    logic        res_valid;
    logic        res_ready;

    // unpack the command, lowest field first
    assign cmd.cmd          = s_axis_tuser;
    assign cmd.entry_index  = s_axis_tdata[IDX_W-1:0];
    assign cmd.entry_value  = s_axis_tdata[IDX_W +: ENTRY_W];
    assign cmd.link_from    = s_axis_tdata[IDX_W + ENTRY_W +: IDX_W];

    // table, hint, free count and the command sequencer
    cat_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (s_axis_tvalid),
        .cmd_ready   (s_axis_tready),
        .cmd         (cmd),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // output register so the engine can start the next command while a result waits
    cat_out_buf u_out_buf (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (res_valid),
        .in_ready      (res_ready),
        .in_res        (res),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

[rtl/cat_engine.sv]
`include "cluster_allocation_table_defines.svh"

module cat_engine
    import cat_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CNT_W-1:0]  cfg_wr_data,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cat_cmd_t          cmd,
    output logic              res_valid,
    input  logic              res_ready,
    output cat_result_t       res
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_LINK   = 3'd3;
    localparam logic [2:0] ST_RDWAIT = 3'd4;
    localparam logic [2:0] ST_WALK   = 3'd5;
    localparam logic [2:0] ST_RESP   = 3'd6;

    logic [ENTRY_W-1:0] mem [CLUSTERS];
    logic [ENTRY_W-1:0] mem_q_reg;
    logic               byp_valid_reg;
    logic [ENTRY_W-1:0] byp_data_reg;
    logic [ENTRY_W-1:0] rdata;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    ciu_reg;
    logic [CNT_W-1:0]    hint_reg, hint_next;
    logic [CNT_W-1:0]    free_reg, free_next;
    logic [IDX_W-1:0]    clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0]    limit_reg, limit_next;
    logic [CNT_W-1:0]    end2_reg, end2_next;
    logic [CNT_W-1:0]    scan_addr_reg, scan_addr_next;
    logic                scan_phase_reg, scan_phase_next;
    logic                chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic [IDX_W-1:0]    prev_reg, prev_next;
    logic [IDX_W-1:0]    walk_c_reg, walk_c_next;
    logic [CNT_W-1:0]    steps_reg, steps_next;
    logic [STATUS_W-1:0] sts_reg, sts_next;
    logic [IDX_W-1:0]    clus_reg, clus_next;
    logic [ENTRY_W-1:0]  rdv_reg, rdv_next;

    logic [CNT_W-1:0] start_w;
    logic [CNT_W-1:0] limit_w;
    logic             found;

    // synchronous table, read data registered and available in the cycle after the address
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q_reg <= mem[mem_raddr];
        end
    end

    // a read that meets a write to the same entry sees the new value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_valid_reg <= 1'b0;
        end else begin
            byp_valid_reg <= mem_we && mem_re && (mem_waddr == mem_raddr);
        end
        byp_data_reg <= mem_wdata;
    end

    assign rdata = byp_valid_reg ? byp_data_reg : mem_q_reg;

    assign start_w = (hint_reg < CNT_W'(FIRST_DATA)) ? CNT_W'(FIRST_DATA) : hint_reg;
    assign limit_w = (ciu_reg > CNT_W'(CLUSTERS)) ? CNT_W'(CLUSTERS) : ciu_reg;
    assign found   = chk_valid_reg && (rdata == '0);

    assign cmd_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_RESP);
    assign res.status          = sts_reg;
    assign res.cluster         = clus_reg;
    assign res.entry_value_out = rdv_reg;
    assign res.free_clusters   = free_reg;

    always_comb begin
        state_next      = state_reg;
        hint_next       = hint_reg;
        free_next       = free_reg;
        clr_addr_next   = clr_addr_reg;
        limit_next      = limit_reg;
        end2_next       = end2_reg;
        scan_addr_next  = scan_addr_reg;
        scan_phase_next = scan_phase_reg;
        chk_valid_next  = chk_valid_reg;
        chk_idx_next    = chk_idx_reg;
        prev_next       = prev_reg;
        walk_c_next     = walk_c_reg;
        steps_next      = steps_reg;
        sts_next        = sts_reg;
        clus_next       = clus_reg;
        rdv_next        = rdv_reg;
        mem_we          = 1'b0;
        mem_waddr       = walk_c_reg;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = cmd.entry_index;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                if (clr_addr_reg == IDX_W'(0)) begin
                    mem_wdata = MEDIA_ENTRY;
                end else if (clr_addr_reg == IDX_W'(1) || clr_addr_reg == IDX_W'(2)) begin
                    mem_wdata = END_CHAIN;
                end
                clr_addr_next = clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == IDX_W'(CLUSTERS - 1)) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (cmd_valid) begin
                    sts_next       = STS_OK;
                    clus_next      = '0;
                    rdv_next       = '0;
                    chk_valid_next = 1'b0;
                    unique case (cmd.cmd)
                        CMD_ALLOC: begin
                            limit_next      = limit_w;
                            end2_next       = (start_w < limit_w) ? start_w : limit_w;
                            scan_addr_next  = start_w;
                            scan_phase_next = 1'b0;
                            prev_next       = cmd.link_from;
                            state_next      = ST_SCAN;
                        end
                        CMD_FREE: begin
                            if (cmd.entry_index < IDX_W'(FIRST_DATA)) begin
                                state_next = ST_RESP;
                            end else begin
                                mem_re      = 1'b1;
                                walk_c_next = cmd.entry_index;
                                steps_next  = '0;
                                state_next  = ST_WALK;
                            end
                        end
                        CMD_READ: begin
                            mem_re     = 1'b1;
                            state_next = ST_RDWAIT;
                        end
                        CMD_WRITE: begin
                            mem_we     = 1'b1;
                            mem_waddr  = cmd.entry_index;
                            mem_wdata  = cmd.entry_value;
                            state_next = ST_RESP;
                        end
                        default: ;
                    endcase
                end
            end

            ST_SCAN: begin
                chk_valid_next = 1'b0;
                if (found) begin
                    mem_we     = 1'b1;
                    mem_waddr  = chk_idx_reg;
                    mem_wdata  = END_CHAIN;
                    hint_next  = {1'b0, chk_idx_reg} + CNT_W'(1);
                    free_next  = (free_reg != '0) ? free_reg - CNT_W'(1) : '0;
                    clus_next  = chk_idx_reg;
                    state_next = (prev_reg != '0) ? ST_LINK : ST_RESP;
                end else if (!scan_phase_reg && scan_addr_reg < limit_reg) begin
                    mem_re         = 1'b1;
                    mem_raddr      = scan_addr_reg[IDX_W-1:0];
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_addr_reg[IDX_W-1:0];
                    scan_addr_next = scan_addr_reg + CNT_W'(1);
                end else if (!scan_phase_reg) begin
                    // wrap to the first data cluster
                    scan_phase_next = 1'b1;
                    scan_addr_next  = CNT_W'(FIRST_DATA);
                end else if (scan_addr_reg < end2_reg) begin
                    mem_re         = 1'b1;
                    mem_raddr      = scan_addr_reg[IDX_W-1:0];
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_addr_reg[IDX_W-1:0];
                    scan_addr_next = scan_addr_reg + CNT_W'(1);
                end else if (!chk_valid_reg) begin
                    sts_next   = STS_NO_FREE;
                    state_next = ST_RESP;
                end
            end

            ST_LINK: begin
                mem_we     = 1'b1;
                mem_waddr  = prev_reg;
                mem_wdata  = {{(ENTRY_W - IDX_W){1'b0}}, clus_reg};
                state_next = ST_RESP;
            end

            ST_RDWAIT: begin
                rdv_next   = rdata;
                state_next = ST_RESP;
            end

            ST_WALK: begin
                // free the current link and follow it in the same cycle
                mem_we     = 1'b1;
                mem_waddr  = walk_c_reg;
                mem_wdata  = '0;
                free_next  = (free_reg < CNT_W'(MAX_FREE)) ? free_reg + CNT_W'(1) : free_reg;
                steps_next = steps_reg + CNT_W'(1);
                if (rdata < ENTRY_W'(FIRST_DATA) || rdata >= BAD_MARK) begin
                    state_next = ST_RESP;
                end else if (rdata >= ENTRY_W'(CLUSTERS)) begin
                    sts_next   = STS_RANGE;
                    state_next = ST_RESP;
                end else if (steps_reg == CNT_W'(CLUSTERS - 1)) begin
                    sts_next   = STS_ABORT;
                    state_next = ST_RESP;
                end else begin
                    mem_re      = 1'b1;
                    mem_raddr   = rdata[IDX_W-1:0];
                    walk_c_next = rdata[IDX_W-1:0];
                end
            end

            ST_RESP: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            ciu_reg       <= CNT_W'(CLUSTERS);
            hint_reg      <= CNT_W'(3);
            free_reg      <= CNT_W'(MAX_FREE);
            clr_addr_reg  <= '0;
            chk_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            hint_reg      <= hint_next;
            free_reg      <= free_next;
            clr_addr_reg  <= clr_addr_next;
            chk_valid_reg <= chk_valid_next;
            if (cfg_wr_en) begin
                ciu_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        limit_reg      <= limit_next;
        end2_reg       <= end2_next;
        scan_addr_reg  <= scan_addr_next;
        scan_phase_reg <= scan_phase_next;
        chk_idx_reg    <= chk_idx_next;
        prev_reg       <= prev_next;
        walk_c_reg     <= walk_c_next;
        steps_reg      <= steps_next;
        sts_reg        <= sts_next;
        clus_reg       <= clus_next;
        rdv_reg        <= rdv_next;
    end

    `CAT_ASSERT_NOW(a_no_cmd_while_clearing, aclk, aresetn, state_reg == ST_CLEAR, !cmd_ready && mem_we, "command taken or table idle during clearing pass")
    `CAT_ASSERT_NOW(a_scan_writes_free_entry, aclk, aresetn, state_reg == ST_SCAN && mem_we, chk_valid_reg && rdata == '0, "allocation wrote an entry that was not free")
    `CAT_ASSERT_NEXT(a_result_held, aclk, aresetn, res_valid && !res_ready, res_valid && $stable(sts_reg) && $stable(free_reg), "pending result changed before it was taken")
    `CAT_ASSERT_NOW(a_walk_in_range, aclk, aresetn, state_reg == ST_WALK, walk_c_reg >= IDX_W'(FIRST_DATA) && steps_reg < CNT_W'(CLUSTERS), "chain walk outside its bounds")

endmodule

[rtl/cat_out_buf.sv]
module cat_out_buf
    import cat_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  cat_result_t            in_res,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [STATUS_W-1:0]    m_axis_tuser
);

    logic        full_reg;
    cat_result_t data_reg;

    assign in_ready = !full_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else if (in_ready) begin
            full_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= in_res;
        end
    end

    assign m_axis_tvalid = full_reg;
    assign m_axis_tuser  = data_reg.status;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_BITS){1'b0}},
                            data_reg.free_clusters,
                            data_reg.entry_value_out,
                            data_reg.cluster};

endmodule
